>>> hw/rtl/squared_exponential_kernel_unit_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef SQUARED_EXPONENTIAL_KERNEL_UNIT_MACROS_SVH
`define SQUARED_EXPONENTIAL_KERNEL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SEK_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sek assertion failed");
`define SEK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sek assertion failed");
`else
`define SEK_ASSERT(lbl, prop)
`define SEK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/sek_pkg.sv
package sek_pkg;

	localparam int ACC_W  = 40;
	localparam int DIFF_W = 17;
	localparam int SQ_W   = 33;

	localparam logic [ACC_W-1:0] ACC_MAX       = '1;
	localparam logic [31:0]      EXP_NEG_ONE   = 32'd1580030169;
	localparam logic [31:0]      EXP_INT_LIMIT = 32'd24;
	localparam logic [3:0]       TAYLOR_ORDER  = 4'd13;
	localparam logic [63:0]      HALF_Q32      = 64'h0000_0000_8000_0000;
	localparam logic [33:0]      ONE_Q32       = 34'h1_0000_0000;

	localparam logic [31:0] GAIN_RESET  = 32'd65536;
	localparam logic [23:0] DECAY_RESET = 24'd32768;

	localparam logic [1:0] REG_SIGNAL_GAIN = 2'd0;
	localparam logic [1:0] REG_DECAY_RATE  = 2'd1;

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             sat;
	} dist_item_t;

	typedef struct packed {
		logic       push;
		dist_item_t item;
	} q_push_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

>>> hw/rtl/sek_front.sv
module sek_front import sek_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // first_elem [15:0], second_elem [31:16]
	input  logic        s_tlast,   // last_elem
	input  q_stat_t     q_stat,
	output q_push_t     q_push
);

	logic                     advance;
	logic signed [DIFF_W-1:0] diff;
	logic                     valid_s1, last_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [2*DIFF_W-1:0] sq_full;
	logic                     valid_s2, last_s2;
	logic [SQ_W-1:0]          sq_s2;
	logic [ACC_W-1:0]         acc_q;
	logic                     ovf_q;
	logic [ACC_W:0]           sum_ext;
	logic                     sat_now;
	logic [ACC_W-1:0]         new_sum;
	logic                     new_sat;

	assign advance  = !(valid_s2 && last_s2 && q_stat.full);
	assign s_tready = advance;

	assign diff = $signed({s_tdata[15], s_tdata[15:0]}) - $signed({s_tdata[31], s_tdata[31:16]});
	assign sq_full = diff_s1 * diff_s1;

	assign sum_ext = {1'b0, acc_q} + {{(ACC_W + 1 - SQ_W){1'b0}}, sq_s2};
	assign sat_now = sum_ext[ACC_W];
	assign new_sum = sat_now ? ACC_MAX : sum_ext[ACC_W-1:0];
	assign new_sat = ovf_q | sat_now;

	assign q_push.push     = valid_s2 && last_s2 && advance;
	assign q_push.item.sum = new_sum;
	assign q_push.item.sat = new_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (last_s2) begin
					acc_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					acc_q <= new_sum;
					ovf_q <= new_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			diff_s1 <= diff;
			last_s1 <= s_tlast;
			sq_s2   <= sq_full[SQ_W-1:0];
			last_s2 <= last_s1;
		end
	end

endmodule

>>> hw/rtl/sek_queue.sv
`include "squared_exponential_kernel_unit_macros.svh"

module sek_queue import sek_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  q_push_t    q_push,
	input  logic       pop,
	output q_stat_t    q_stat,
	output dist_item_t rd_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dist_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));
	assign do_push      = q_push.push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign rd_item      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= q_push.item;
	end

	`SEK_ASSERT(a_no_push_full, !(q_push.push && q_stat.full))
	`SEK_ASSERT(a_no_pop_empty, !(pop && q_stat.empty))
	`SEK_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))

endmodule

>>> hw/rtl/sek_back.sv
`include "squared_exponential_kernel_unit_macros.svh"

module sek_back import sek_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dist_item_t  rd_item,
	input  q_stat_t     q_stat,
	output logic        pop,
	input  logic [31:0] signal_gain,
	input  logic [23:0] decay_rate,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // kernel_value [31:0]
	output logic        m_tuser    // sum_saturated
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MX0   = 4'd1;
	localparam logic [3:0] ST_MX1   = 4'd2;
	localparam logic [3:0] ST_MX2   = 4'd3;
	localparam logic [3:0] ST_MX3   = 4'd4;
	localparam logic [3:0] ST_TMUL  = 4'd5;
	localparam logic [3:0] ST_TDIV  = 4'd7;
	localparam logic [3:0] ST_TACC  = 4'd8;
	localparam logic [3:0] ST_TSUB  = 4'd9;
	localparam logic [3:0] ST_RMUL  = 4'd10;
	localparam logic [3:0] ST_RRND  = 4'd11;
	localparam logic [3:0] ST_GMUL  = 4'd12;
	localparam logic [3:0] ST_GRND  = 4'd13;
	localparam logic [3:0] ST_OUT   = 4'd14;

	logic [3:0]       state_q;
	logic [ACC_W-1:0] sum_q;
	logic             sat_q;
	logic [63:0]      mul_q, x_q, rnd;
	logic [31:0]      f_q, term_q, div_q, kern_q;
	logic [4:0]       n_q;
	logic [33:0]      pos_q, neg_q;
	logic [3:0]       k_q;
	logic [32:0]      y_q;
	logic [31:0]      op_a, op_b;
	logic [63:0]      prod;
	logic [32:0]      quo_sum, quo_shr;
	logic [31:0]      quo;
	logic             out_free;
	logic             m_tvalid_q, m_tuser_q;
	logic [31:0]      m_tdata_q;

	// low word of ceil(2^(32+l) / k), l = ceil(log2 k); the 2^32 part comes back as + t
	function automatic logic [31:0] recip_low(input logic [3:0] k);
		logic [31:0] r;
		unique case (k)
			4'd3, 4'd6, 4'd12: r = 32'd1431655766;
			4'd5, 4'd10:       r = 32'd2576980378;
			4'd7:              r = 32'd613566757;
			4'd9:              r = 32'd3340530120;
			4'd11:             r = 32'd1952257862;
			4'd13:             r = 32'd991146300;
			default:           r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] recip_shift(input logic [3:0] k);
		logic [2:0] s;
		unique case (k)
			4'd2:                   s = 3'd1;
			4'd3, 4'd4:             s = 3'd2;
			4'd5, 4'd6, 4'd7, 4'd8: s = 3'd3;
			default:                s = 3'd4;
		endcase
		return s;
	endfunction

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// shared 32x32 multiplier
	always_comb begin
		unique case (state_q)
			ST_MX0:  begin op_a = {8'b0, decay_rate}; op_b = sum_q[31:0]; end
			ST_MX1:  begin op_a = {8'b0, decay_rate}; op_b = {24'b0, sum_q[ACC_W-1:32]}; end
			ST_TMUL: begin op_a = term_q;             op_b = f_q; end
			ST_TDIV: begin op_a = mul_q[63:32];       op_b = recip_low(k_q); end
			ST_RMUL: begin op_a = y_q[31:0];          op_b = EXP_NEG_ONE; end
			ST_GMUL: begin op_a = signal_gain;        op_b = y_q[31:0]; end
			default: begin op_a = '0;                 op_b = '0; end
		endcase
	end
	assign prod = op_a * op_b;
	assign rnd  = mul_q + HALF_Q32;

	// divide by the term index: (t + hi(t * recip)) >> l
	assign quo_sum = {1'b0, div_q} + {1'b0, mul_q[63:32]};
	assign quo_shr = quo_sum >> recip_shift(k_q);
	assign quo     = quo_shr[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                 m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE:  if (pop) state_q <= ST_MX0;
				ST_MX0:   state_q <= ST_MX1;
				ST_MX1:   state_q <= ST_MX2;
				ST_MX2:   state_q <= ST_MX3;
				ST_MX3:   state_q <= (x_q[63:32] >= EXP_INT_LIMIT) ? ST_OUT : ST_TMUL;
				ST_TMUL:  state_q <= ST_TDIV;
				ST_TDIV:  state_q <= ST_TACC;
				ST_TACC:  state_q <= (k_q == TAYLOR_ORDER) ? ST_TSUB : ST_TMUL;
				ST_TSUB:  state_q <= (n_q == '0) ? ST_GMUL : ST_RMUL;
				ST_RMUL:  state_q <= ST_RRND;
				ST_RRND:  state_q <= (n_q == 5'd1) ? ST_GMUL : ST_RMUL;
				ST_GMUL:  state_q <= ST_GRND;
				ST_GRND:  state_q <= ST_OUT;
				ST_OUT:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (pop) begin
				sum_q <= rd_item.sum;
				sat_q <= rd_item.sat;
			end
			ST_MX0: mul_q <= prod;
			ST_MX1: begin
				x_q   <= mul_q;
				mul_q <= prod;
			end
			ST_MX2: x_q <= x_q + {mul_q[31:0], 32'b0};
			ST_MX3: begin
				kern_q <= '0;
				f_q    <= x_q[31:0];
				n_q    <= x_q[36:32];
				term_q <= x_q[31:0];
				pos_q  <= ONE_Q32;
				neg_q  <= {2'b0, x_q[31:0]};
				k_q    <= 4'd2;
			end
			ST_TMUL: mul_q <= prod;
			ST_TDIV: begin
				div_q <= mul_q[63:32];
				mul_q <= prod;
			end
			ST_TACC: begin
				term_q <= quo;
				if (k_q[0]) neg_q <= neg_q + {2'b0, quo};
				else        pos_q <= pos_q + {2'b0, quo};
				k_q <= k_q + 1'b1;
			end
			ST_TSUB: y_q <= (neg_q > pos_q) ? '0 : 33'(pos_q - neg_q);
			// y is at most 1.0; 1.0 times a constant is the constant
			ST_RMUL: mul_q <= y_q[32] ? {EXP_NEG_ONE, 32'b0} : prod;
			ST_RRND: begin
				y_q <= {1'b0, rnd[63:32]};
				n_q <= n_q - 1'b1;
			end
			ST_GMUL: mul_q <= y_q[32] ? {signal_gain, 32'b0} : prod;
			ST_GRND: kern_q <= rnd[63:32];
			ST_OUT: if (out_free) begin
				m_tdata_q <= kern_q;
				m_tuser_q <= sat_q;
			end
			default: ;
		endcase
	end

	`SEK_ASSERT(a_k_range, !(state_q == ST_TMUL) || (k_q >= 4'd2 && k_q <= TAYLOR_ORDER))
	`SEK_ASSERT(a_reduce_count, !(state_q == ST_RMUL) || (n_q != '0))
	`SEK_ASSERT_NEXT(a_pop_starts, pop, state_q == ST_MX0)

endmodule

>>> hw/rtl/squared_exponential_kernel_unit.sv
// Pairs go in one per cycle unless stalled; difference and square are registered, then summed.
// The exp unit pops one sum at a time, only when idle (n = integer exponent part):
// result 0 when n >= 24, else 12 Taylor terms (multiply, divide, add), then n e^-1 steps.
// Up to QUEUE_DEPTH finished sums wait for the exp unit; the front stalls only when it is full.
// Asynchronous active-low reset clears the sum, the queue and the sequencer, and loads
// signal_gain = 1.0 and decay_rate = 0.5.
module squared_exponential_kernel_unit import sek_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // first_elem [15:0], second_elem [31:16]
	input  logic        s_tlast,    // last_elem
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // kernel_value [31:0]
	output logic        m_tuser,    // sum_saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] signal_gain_q;
	logic [23:0] decay_rate_q;
	q_push_t     q_push;
	q_stat_t     q_stat;
	dist_item_t  rd_item;
	logic        pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signal_gain_q <= GAIN_RESET;
			decay_rate_q  <= DECAY_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SIGNAL_GAIN)     signal_gain_q <= cfg_data;
			else if (cfg_index == REG_DECAY_RATE) decay_rate_q  <= cfg_data[23:0];
		end
	end

	sek_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_stat   (q_stat),
		.q_push   (q_push)
	);

	sek_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.pop     (pop),
		.q_stat  (q_stat),
		.rd_item (rd_item)
	);

	sek_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_item     (rd_item),
		.q_stat      (q_stat),
		.pop         (pop),
		.signal_gain (signal_gain_q),
		.decay_rate  (decay_rate_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

endmodule

>>> test/squared_exponential_kernel_unit_checker.sv
`timescale 1ns / 1ps

module squared_exponential_kernel_unit_checker import sek_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,    // first_elem [15:0], second_elem [31:16]
	input  logic        s_tlast,    // last_elem
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,    // kernel_value [31:0]
	input  logic        m_tuser,    // sum_saturated
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          kernels_checked,
	output int          saturated_checked
);

	typedef struct packed {
		logic [31:0] value;
		logic        sat;
	} kernel_result_t;

	kernel_result_t pending_kernels[$];

	logic [31:0] gain;
	logic [23:0] rate;
	logic [39:0] dist_sum;
	logic        dist_sat;

	// gain * exp(-rate * sum), Q16.16 result
	function automatic logic [31:0] gaussian_kernel(input logic [39:0] sq_dist,
			input logic [31:0] sig_gain, input logic [23:0] decay);
		logic [63:0] x;
		logic [63:0] frac;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] y;
		logic [63:0] prod;
		logic [31:0] n;
		int          k;
		int          i;
		x = 64'(decay) * 64'(sq_dist);
		n = x[63:32];
		if (n >= EXP_INT_LIMIT)
			return 32'd0;
		frac = {32'd0, x[31:0]};
		term = 64'(ONE_Q32);
		pos = term;
		neg = 64'd0;
		for (k = 1; k <= int'(TAYLOR_ORDER); k++) begin
			term = ((term * frac) >> 32) / 64'(k);
			if (k % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		y = (neg > pos) ? 64'd0 : pos - neg;
		for (i = 0; i < int'(n); i++)
			y = (y * 64'(EXP_NEG_ONE) + HALF_Q32) >> 32;
		prod = (64'(sig_gain) * y + HALF_Q32) >> 32;
		return prod[31:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		kernel_result_t want;
		logic [16:0]    diff;
		logic [16:0]    mag;
		logic [63:0]    sq;
		int             errs;
		if (!arst_n) begin
			gain = GAIN_RESET;
			rate = DECAY_RESET;
			dist_sum = '0;
			dist_sat = 1'b0;
			pending_kernels.delete();
			mismatches <= 0;
			outstanding <= 0;
			kernels_checked <= 0;
			saturated_checked <= 0;
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SIGNAL_GAIN: gain = cfg_data;
					REG_DECAY_RATE: rate = cfg_data[23:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				diff = {s_tdata[15], s_tdata[15:0]} - {s_tdata[31], s_tdata[31:16]};
				mag = diff[16] ? -diff : diff;
				sq = 64'(mag) * 64'(mag);
				if (64'(dist_sum) > 64'(ACC_MAX) - sq) begin
					dist_sum = ACC_MAX;
					dist_sat = 1'b1;
				end else begin
					dist_sum = dist_sum + sq[39:0];
				end
				if (s_tlast) begin
					want.value = gaussian_kernel(dist_sum, gain, rate);
					want.sat = dist_sat;
					pending_kernels.push_back(want);
					dist_sum = '0;
					dist_sat = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (pending_kernels.size() == 0) begin
					$display("%0t: unexpected kernel item, expected none actual %h sat %b",
						$time, m_tdata, m_tuser);
					errs++;
				end else begin
					want = pending_kernels.pop_front();
					if (m_tdata !== want.value) begin
						$display("%0t: kernel_value mismatch, expected %h actual %h",
							$time, want.value, m_tdata);
						errs++;
					end
					if (m_tuser !== want.sat) begin
						$display("%0t: sum_saturated mismatch, expected %b actual %b",
							$time, want.sat, m_tuser);
						errs++;
					end
					kernels_checked <= kernels_checked + 1;
					if (want.sat)
						saturated_checked <= saturated_checked + 1;
				end
			end
			mismatches <= mismatches + errs;
			outstanding <= pending_kernels.size();
		end
	end

endmodule

>>> test/squared_exponential_kernel_unit_tb.sv
`timescale 1ns / 1ps

module squared_exponential_kernel_unit_tb;
	import sek_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam int DRAIN_TAIL  = 16;
	localparam int END_TAIL    = 64;
	localparam int RANDOM_ITEMS = 170;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // first_elem [15:0], second_elem [31:16]
	logic        s_tlast;    // last_elem
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // kernel_value [31:0]
	logic        m_tuser;    // sum_saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	int mismatches;
	int outstanding;
	int kernels_checked;
	int saturated_checked;

	int items_sent;
	int vectors_sent;
	int cfg_writes;
	int input_stalls;
	int quiet_cycles;
	int burst_left;
	int hold_seq;
	bit no_gaps;

	squared_exponential_kernel_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	squared_exponential_kernel_unit_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tlast           (s_tlast),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.m_tuser           (m_tuser),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.mismatches        (mismatches),
		.outstanding       (outstanding),
		.kernels_checked   (kernels_checked),
		.saturated_checked (saturated_checked)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (s_tvalid && !s_tready)
			input_stalls <= input_stalls + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: timeout, no item moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL squared_exponential_kernel_unit");
			$finish;
		end
	end

	// result side: stall patterns, plus a long hold-off on request
	initial begin : receiver
		int last_hold;
		int mode;
		int mode_left;
		m_tready = 1'b0;
		last_hold = 0;
		mode = 0;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (hold_seq != last_hold) begin
				last_hold = hold_seq;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 4);
					mode_left = $urandom_range(20, 400);
				end
				mode_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 1) == 1);
					2: m_tready <= ($urandom_range(0, 3) != 0);
					3: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 49) == 0);
				endcase
			end
		end
	end

	task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: gap = 0;
				17, 18, 19: gap = $urandom_range(5, 30);
				default: gap = $urandom_range(1, 4);
			endcase
			if (no_gaps)
				gap = 0;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {b, a};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (last)
			vectors_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_TAIL) @(negedge clk);
	endtask

	function automatic logic [15:0] random_elem(input int scale);
		logic [15:0] v;
		case (scale)
			0: v = 16'($urandom_range(0, 1023)) - 16'd512;
			1: v = 16'($urandom_range(0, 16383)) - 16'd8192;
			2: v = 16'($urandom);
			default: begin
				case ($urandom_range(0, 4))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = 16'h0000;
					3: v = 16'hFFFF;
					default: v = 16'h0001;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_random_vector(input int len);
		int scale;
		int i;
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: scale = 0;
			11, 12, 13, 14: scale = 1;
			15, 16, 17: scale = 2;
			default: scale = 3;
		endcase
		for (i = 0; i < len; i++)
			send_pair(random_elem(scale), random_elem(scale), i == len - 1);
	endtask

	// pairs near full scale with opposite signs drive the sum into saturation
	task automatic send_saturating_vector(input int len);
		logic [15:0] hi;
		logic [15:0] lo;
		int          i;
		for (i = 0; i < len; i++) begin
			hi = 16'h7FFF - 16'($urandom_range(0, 15));
			lo = 16'h8000 + 16'($urandom_range(0, 15));
			if ($urandom_range(0, 1) == 1)
				send_pair(hi, lo, i == len - 1);
			else
				send_pair(lo, hi, i == len - 1);
		end
	endtask

	function automatic int random_length();
		int len;
		case ($urandom_range(0, 49))
			0: len = 64;
			1, 2, 3, 4: len = $urandom_range(17, 64);
			5, 6, 7, 8, 9, 10, 11, 12, 13, 14: len = $urandom_range(5, 16);
			default: len = $urandom_range(1, 4);
		endcase
		return len;
	endfunction

	task automatic random_config();
		logic [31:0] gain;
		logic [23:0] decay;
		case ($urandom_range(0, 4))
			0: gain = 32'hFFFF_FFFF;
			1: gain = 32'd0;
			2: gain = 32'd65536;
			3: gain = $urandom;
			default: gain = $urandom_range(0, 1 << 20);
		endcase
		case ($urandom_range(0, 5))
			0: decay = 24'd0;
			1: decay = 24'hFF_FFFF;
			2, 3: decay = 24'($urandom_range(0, 65535));
			4: decay = 24'($urandom_range(0, 1 << 18));
			default: decay = 24'($urandom);
		endcase
		write_reg(REG_SIGNAL_GAIN, gain);
		write_reg(REG_DECAY_RATE, {8'd0, decay});
	endtask

	initial begin : stimulus
		int phase;
		int phase_items;
		int random_start;
		int i;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_SIGNAL_GAIN;
		cfg_data = '0;
		items_sent = 0;
		vectors_sent = 0;
		cfg_writes = 0;
		input_stalls = 0;
		quiet_cycles = 0;
		burst_left = 0;
		hold_seq = 0;
		no_gaps = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// reset settings: zero distance, full-scale distances, half-unit exponent
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h8000, 16'h7FFF, 1'b1);
		send_pair(16'h0100, 16'h0000, 1'b1);
		send_pair(16'd100, -16'sd50, 1'b0);
		send_pair(-16'sd200, 16'd300, 1'b0);
		send_pair(16'd5, 16'd5, 1'b1);
		send_pair(16'h8000, 16'h8000, 1'b1);
		send_pair(16'h7FFF, 16'h7FFF, 1'b1);
		wait_drained();

		// decay 1.5: distance 16.0 lands exactly on the exponent limit
		write_reg(REG_DECAY_RATE, 32'd98304);
		send_pair(16'd1024, 16'd0, 1'b1);
		send_pair(16'd1023, 16'd0, 1'b1);
		send_pair(16'h0000, 16'hFC00, 1'b1);
		wait_drained();

		// full gain, no decay: result equals gain, also through saturation
		write_reg(REG_SIGNAL_GAIN, 32'hFFFF_FFFF);
		write_reg(REG_DECAY_RATE, 32'd0);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		send_pair(16'h1234, 16'h1234, 1'b1);
		send_saturating_vector(262);
		wait_drained();

		write_reg(REG_SIGNAL_GAIN, 32'd0);
		write_reg(REG_DECAY_RATE, 32'h00FF_FFFF);
		send_pair(16'h0000, 16'h0000, 1'b1);
		send_pair(16'h0001, 16'h0000, 1'b1);
		wait_drained();

		random_start = items_sent;
		phase = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			random_config();
			no_gaps = ($urandom_range(0, 3) == 0);
			phase_items = items_sent + $urandom_range(40, 80);
			if (phase == 1) begin
				hold_seq++;
				no_gaps = 1'b1;
				for (i = 0; i < 16; i++)
					send_random_vector(1);
				no_gaps = 1'b0;
			end
			while (items_sent < phase_items)
				send_random_vector(random_length());
			wait_drained();
			phase++;
		end

		while (outstanding != 0) @(negedge clk);
		repeat (END_TAIL) @(negedge clk);
		$display("sent %0d element pairs in %0d vectors, %0d register writes, %0d input stalls",
			items_sent, vectors_sent, cfg_writes, input_stalls);
		$display("compared %0d kernel values, %0d of them from a saturated sum",
			kernels_checked, saturated_checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS squared_exponential_kernel_unit");
		end else begin
			$display("FAIL squared_exponential_kernel_unit");
		end
		$finish;
	end

endmodule
